[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed in %m");

// Checked on every rising clk edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed in %m");

`endif

[hw/rtl/cdd_pkg.sv]
// ---------------------------------------------------------------------------
// cdd_pkg
// Types, codes and calendar tables for the date decrement block.
// ---------------------------------------------------------------------------
package cdd_pkg;

  typedef struct packed {
    logic signed [15:0] in_year;
    logic [3:0]         in_month;
    logic [4:0]         in_day;
    logic [1:0]         opcode;
    logic [15:0]        step_count;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] out_year;
    logic [3:0]         out_month;
    logic [4:0]         out_day;
  } out_beat_t;

  // Opcodes
  localparam logic [1:0] OP_DAYS       = 2'd0;
  localparam logic [1:0] OP_MONTHS     = 2'd1;
  localparam logic [1:0] OP_YEARS_STEP = 2'd2;
  localparam logic [1:0] OP_YEARS_DIR  = 2'd3;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] DAY_FIRST  = 5'd1;
  localparam logic [4:0] DAY_LEAP   = 5'd29;
  localparam logic [4:0] DAY_FEB    = 5'd28;
  localparam logic [4:0] DAY_DEC    = 5'd31;

  // x divisible by 25 iff (x * INV25) mod 2^16 <= DIV25_LIMIT (x unsigned, 16 bits)
  localparam logic [15:0] INV25       = 16'd23593;
  localparam logic [15:0] DIV25_LIMIT = 16'd2621;

  function automatic logic [4:0] cdd_month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? DAY_LEAP : DAY_FEB;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[hw/rtl/calendar_date_decrement_top.sv]
// ---------------------------------------------------------------------------
// calendar_date_decrement_top
// Moves a proleptic Gregorian date back by a count of days, months or years.
// ---------------------------------------------------------------------------
//
//  channel | ports                          | dir | content
//  --------+--------------------------------+-----+------------------------------------
//  input   | in_valid, in_ready, in_data    | in  | year, month, day, opcode, count
//  result  | out_valid, out_ready, out_data | out | year, month, day (one per input)
//
// Stepping: days and months take one step per count; a year crossed before the
//   last step reruns the leap check (S_ABS, S_CHK) before stepping on. Both year
//   opcodes run the leap check, subtract in S_NORM, check again, then go to S_FIX.
//   The month loop is the long pole, with count 65535 the longest item.
// One beat is in flight at a time; in_ready is high only while idle.
// The result register frees the input side: a new beat is taken while a result
//   still waits for out_ready. A finished item holds in its last state until the
//   result register is free.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid.
module calendar_date_decrement_top import cdd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a beat
    S_ABS,    // leap check, step 1: magnitude of the year
    S_CHK,    // leap check, step 2: divisibility tests
    S_NORM,   // clamp the start day; year opcodes subtract here
    S_STEP,   // one day or one month back per cycle, paused by the leap check after a year change
    S_FIX,    // 29 February rule for the year opcodes
    S_DONE    // hand the result to the output register
  } state_t;

  state_t             state_r, state_nxt;
  state_t             ret_r, ret_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r;
  logic               out_load;

  logic signed [15:0] year_r, year_nxt;
  logic [3:0]         month_r, month_nxt;
  logic [4:0]         day_r, day_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [15:0]        cnt_r, cnt_nxt;
  logic [15:0]        abs_r, abs_nxt;
  logic               leap_r, leap_nxt;

  // Shared year subtractor: negate for magnitude, decrement, or subtract count.
  logic [15:0]        sub_a, sub_b, sub_y;
  logic [15:0]        prod_lo;
  logic [4:0]         len_cur, len_dn;
  logic [3:0]         month_dn;
  logic [15:0]        cnt_dn;
  logic               ychg;

  assign sub_y    = sub_a - sub_b;
  // only the low 16 bits of the product matter for the divisibility test
  assign prod_lo  = abs_r * INV25;
  assign month_dn = month_r - 4'd1;
  assign len_cur  = cdd_month_days(month_r, leap_r);
  assign len_dn   = cdd_month_days(month_dn, leap_r);
  assign cnt_dn   = cnt_r - 16'd1;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    abs_nxt   = abs_r;
    leap_nxt  = leap_r;
    out_load  = 1'b0;
    ychg      = 1'b0;
    sub_a     = year_r;
    sub_b     = 16'd1;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          year_nxt = in_data.in_year;
          if (in_data.in_month == 4'd0) begin
            month_nxt = MONTH_JAN;
          end else if (in_data.in_month > MONTH_DEC) begin
            month_nxt = MONTH_DEC;
          end else begin
            month_nxt = in_data.in_month;
          end
          day_nxt   = (in_data.in_day == 5'd0) ? DAY_FIRST : in_data.in_day;
          op_nxt    = in_data.opcode;
          cnt_nxt   = in_data.step_count;
          ret_nxt   = S_NORM;
          state_nxt = S_ABS;
        end
      end
      S_ABS: begin
        sub_a     = 16'd0;
        sub_b     = year_r;
        abs_nxt   = year_r[15] ? sub_y : year_r;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // leap: divisible by 4, and not by 25 unless also by 16 (i.e. by 400)
        leap_nxt  = (year_r[1:0] == 2'd0) &&
                    ((prod_lo > DIV25_LIMIT) || (year_r[3:0] == 4'd0));
        state_nxt = ret_r;
      end
      S_NORM: begin
        if (day_r > len_cur) begin
          day_nxt = len_cur;
        end
        if (op_r == OP_DAYS || op_r == OP_MONTHS) begin
          state_nxt = (cnt_r == 16'd0) ? S_DONE : S_STEP;
        end else begin
          sub_b     = cnt_r;
          year_nxt  = sub_y;
          ret_nxt   = S_FIX;
          state_nxt = S_ABS;
        end
      end
      S_STEP: begin
        cnt_nxt = cnt_dn;
        if (op_r == OP_DAYS) begin
          if (day_r == DAY_FIRST) begin
            if (month_r != MONTH_JAN) begin
              month_nxt = month_dn;
              day_nxt   = len_dn;
            end else begin
              year_nxt  = sub_y;
              month_nxt = MONTH_DEC;
              day_nxt   = DAY_DEC;
              ychg      = 1'b1;
            end
          end else begin
            day_nxt = day_r - 5'd1;
          end
        end else begin
          if (month_r == MONTH_JAN) begin
            // December is 31 days long, so the day never clamps here
            year_nxt  = sub_y;
            month_nxt = MONTH_DEC;
            ychg      = 1'b1;
          end else begin
            month_nxt = month_dn;
            if (day_r > len_dn) begin
              day_nxt = len_dn;
            end
          end
        end
        if (cnt_dn == 16'd0) begin
          state_nxt = S_DONE;
        end else if (ychg) begin
          ret_nxt   = S_STEP;
          state_nxt = S_ABS;
        end
      end
      S_FIX: begin
        // Stepwise years pass a common year whenever two or more are taken.
        if (month_r == MONTH_FEB && day_r == DAY_LEAP &&
            ((op_r == OP_YEARS_STEP && cnt_r > 16'd1) || !leap_r)) begin
          day_nxt = DAY_FEB;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_NORM;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_data_r.out_year  <= year_r;
      out_data_r.out_month <= month_r;
      out_data_r.out_day   <= day_r;
    end
  end

  // Working date and counters
  always_ff @(posedge clk) begin
    year_r  <= year_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
    op_r    <= op_nxt;
    cnt_r   <= cnt_nxt;
    abs_r   <= abs_nxt;
    leap_r  <= leap_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hw/rtl/cdd_checker.sv]
// ---------------------------------------------------------------------------
// cdd_checker
// Port-level checks for the date decrement block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cdd_checker import cdd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // one item at a time: taking a beat closes the input side
  `ASSERT_CLK(a_busy_after_accept, in_fire |=> !in_ready)

  // results are always valid calendar fields
  `ASSERT_CLK(a_month_range, out_valid |-> (out_data.out_month >= 4'd1 && out_data.out_month <= 4'd12))
  `ASSERT_CLK(a_day_range, out_valid |-> (out_data.out_day >= 5'd1 && out_data.out_day <= 5'd31))

  // a stalled result beat holds
  `ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))

  // reset drops the result beat
  `ASSERT_CLK_ALWAYS(a_reset_clears, !rst_n |=> !out_valid)

endmodule

bind calendar_date_decrement_top cdd_checker u_cdd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[sim/tb_calendar_date_decrement_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_calendar_date_decrement_top
// Self-checking bench for the date decrement block: directed corner dates,
// then random traffic with both sides stalling, each result checked against
// a date predictor kept in the bench.
// ---------------------------------------------------------------------------
module tb_calendar_date_decrement_top;
  import cdd_pkg::*;

  // Longest legal item is a month walk of count 65535; the watchdog allows
  // several times its length with no beat moving on either side.
  localparam int WATCHDOG_LIMIT = 500000;
  // Quiet cycles after the last result, to catch a stray extra beat.
  localparam int TAIL_CYCLES    = 20;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  calendar_date_decrement_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Date predictor
  // ---------------------------------------------------------------------------
  // Leap rule on the signed year; SV % truncates toward zero, and a zero
  // remainder test does not care about the sign.
  function automatic logic is_leap_year(logic [15:0] yr);
    int v;
    v = int'($signed(yr));
    return (v % 400 == 0) || (v % 4 == 0 && v % 100 != 0);
  endfunction

  // Only ever called with a month already pulled into 1..12.
  function automatic logic [4:0] days_of_month(logic [3:0] mo, logic [15:0] yr);
    case (mo)
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      MONTH_FEB:               return is_leap_year(yr) ? DAY_LEAP : DAY_FEB;
      default:                 return DAY_DEC;
    endcase
  endfunction

  // 29 Feb landing in a common year drops to the 28th.
  function automatic logic [4:0] fold_leap_day(logic [3:0] mo, logic [4:0] dy,
                                               logic [15:0] yr);
    if (mo == MONTH_FEB && dy == DAY_LEAP && !is_leap_year(yr))
      return DAY_FEB;
    return dy;
  endfunction

  function automatic out_beat_t date_moved_back(in_beat_t cmd);
    logic [15:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    out_beat_t   res;
    yr = cmd.in_year;
    mo = cmd.in_month;
    dy = cmd.in_day;
    // Out-of-range month and day are pulled in before any stepping.
    if (mo < MONTH_JAN) mo = MONTH_JAN;
    if (mo > MONTH_DEC) mo = MONTH_DEC;
    if (dy < DAY_FIRST) dy = DAY_FIRST;
    if (dy > days_of_month(mo, yr)) dy = days_of_month(mo, yr);
    case (cmd.opcode)
      OP_DAYS: begin
        for (int unsigned k = 0; k < cmd.step_count; k++) begin
          if (dy != DAY_FIRST) begin
            dy = dy - 5'd1;
          end else if (mo != MONTH_JAN) begin
            mo = mo - 4'd1;
            dy = days_of_month(mo, yr);
          end else begin
            yr = yr - 16'd1;
            mo = MONTH_DEC;
            dy = DAY_DEC;
          end
        end
      end
      OP_MONTHS: begin
        // Day clamp at every step, so a short month on the way sticks.
        for (int unsigned k = 0; k < cmd.step_count; k++) begin
          if (mo == MONTH_JAN) begin
            yr = yr - 16'd1;
            mo = MONTH_DEC;
          end else begin
            mo = mo - 4'd1;
          end
          if (dy > days_of_month(mo, yr)) dy = days_of_month(mo, yr);
        end
      end
      OP_YEARS_STEP: begin
        for (int unsigned k = 0; k < cmd.step_count; k++) begin
          yr = yr - 16'd1;
          dy = fold_leap_day(mo, dy, yr);
        end
        dy = fold_leap_day(mo, dy, yr);
      end
      default: begin
        yr = yr - cmd.step_count;
        dy = fold_leap_day(mo, dy, yr);
      end
    endcase
    res.out_year  = yr;
    res.out_month = mo;
    res.out_day   = dy;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard, checker and watchdog, all on the rising edge
  // ---------------------------------------------------------------------------
  out_beat_t expected_dates[$];
  out_beat_t want;
  int        mismatches;
  int        results_checked;
  int        cmds_by_op[4];
  int        quiet_cycles;
  bit        steady_flow;     // both sides run without gaps while set
  int        ready_hold;
  logic      ready_level;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_dates.push_back(date_moved_back(in_data));
        cmds_by_op[in_data.opcode]++;
      end
      if (out_valid && out_ready) begin
        if (expected_dates.size() == 0) begin
          $error("result beat with no command outstanding: %0d-%0d-%0d",
                 out_data.out_year, out_data.out_month, out_data.out_day);
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          if (out_data.out_year !== want.out_year) begin
            $error("out_year: expected %0d, got %0d", want.out_year, out_data.out_year);
            mismatches++;
          end
          if (out_data.out_month !== want.out_month) begin
            $error("out_month: expected %0d, got %0d", want.out_month, out_data.out_month);
            mismatches++;
          end
          if (out_data.out_day !== want.out_day) begin
            $error("out_day: expected %0d, got %0d", want.out_day, out_data.out_day);
            mismatches++;
          end
          results_checked++;
        end
      end
      // Watchdog: any beat on either side counts as progress.
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles, %0d results pending",
                 quiet_cycles, expected_dates.size());
        $display("** calendar_date_decrement_top: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side back-pressure: runs of ready high or low, mostly short,
  // now and then a long stall. Held high during steady stretches.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready = 1'b0;
    end else if (steady_flow) begin
      out_ready = 1'b1;
    end else begin
      if (ready_hold == 0) begin
        ready_level = ($urandom_range(0, 99) < 60);
        ready_hold  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 40);
      end else begin
        ready_hold--;
      end
      out_ready = ready_level;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Idle gap before a command: often none, mostly short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Entered and left at a falling edge. Valid stays up (new payload) when
  // the next command follows with no gap.
  task automatic send_cmd(input int yr, input int mo, input int dy,
                          input logic [1:0] op, input int cnt);
    in_beat_t cmd;
    int       gap;
    cmd.in_year    = yr[15:0];
    cmd.in_month   = mo[3:0];
    cmd.in_day     = dy[4:0];
    cmd.opcode     = op;
    cmd.step_count = cnt[15:0];
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Sender goes quiet until every expected result is back.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (expected_dates.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed dates with modest counts; some raw month/day noise,
  // years near the wrap points, and the odd full-range count.
  task automatic send_random_cmd();
    logic [1:0] op;
    int yr, mo, dy, cnt, r;
    op = $urandom_range(0, 3);
    r  = $urandom_range(0, 99);
    if (r < 40)      yr = $urandom_range(1500, 2500);
    else if (r < 65) yr = int'($urandom_range(0, 800)) - 400;
    else if (r < 75) yr = ($urandom_range(0, 1) != 0) ? 32767 - int'($urandom_range(0, 3))
                                                     : -32768 + int'($urandom_range(0, 3));
    else             yr = $urandom_range(0, 65535);
    if ($urandom_range(0, 99) < 85) begin
      mo = $urandom_range(1, 12);
      dy = $urandom_range(1, days_of_month(mo[3:0], yr[15:0]));
    end else begin
      mo = $urandom_range(0, 15);
      dy = $urandom_range(0, 31);
    end
    r = $urandom_range(0, 99);
    if (op == OP_DAYS || op == OP_MONTHS) begin
      // Full-range walks are the slowest commands, so keep them rare.
      if (r < 65)      cnt = $urandom_range(0, 40);
      else if (r < 95) cnt = $urandom_range(0, 2000);
      else             cnt = $urandom_range(0, 65535);
    end else begin
      cnt = (r < 30) ? $urandom_range(0, 10) : $urandom_range(0, 65535);
    end
    send_cmd(yr, mo, dy, op, cnt);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Month 0 and 13..15, day 0, and days past the month's end are pulled in.
  task automatic test_input_clamping();
    send_cmd(2023,  0, 15, OP_DAYS,       0);
    send_cmd(2023, 13,  0, OP_DAYS,       0);
    send_cmd(2023, 15, 31, OP_MONTHS,     1);
    send_cmd(2023, 14,  5, OP_YEARS_STEP, 0);
    send_cmd(2023,  2, 30, OP_DAYS,       0);   // Feb 30, common year
    send_cmd(2024,  2, 31, OP_DAYS,       1);   // Feb 31, leap year
    send_cmd(2023,  4, 31, OP_MONTHS,     0);
  endtask

  // Day walk across month ends, leap Februaries, year end and the year wrap.
  task automatic test_day_steps();
    send_cmd(2024,       3,  1, OP_DAYS, 1);
    send_cmd(2100,       3,  1, OP_DAYS, 1);    // century, not leap
    send_cmd(2000,       1,  1, OP_DAYS, 1);
    send_cmd(-32768,     1,  1, OP_DAYS, 1);    // wraps to 32767
    send_cmd(32767,     12, 31, OP_DAYS, 65535);
  endtask

  // Month walk: clamp carries over from short months.
  task automatic test_month_steps();
    send_cmd(2023,   3, 31, OP_MONTHS, 1);
    send_cmd(2023,   5, 31, OP_MONTHS, 3);      // ends Feb 28, not Feb 31
    send_cmd(-32768, 1, 15, OP_MONTHS, 1);
    send_cmd(0,      7, 31, OP_MONTHS, 65535);
  endtask

  // Both year forms around 29 Feb, negative leap years and the wrap.
  task automatic test_year_steps();
    send_cmd(2024,   2, 29, OP_YEARS_STEP, 1);
    send_cmd(2024,   2, 29, OP_YEARS_STEP, 4);  // stepwise loses the 29th
    send_cmd(2024,   2, 29, OP_YEARS_DIR,  4);  // direct keeps it
    send_cmd(-4,     2, 29, OP_YEARS_DIR,  396);
    send_cmd(-96,    2, 29, OP_YEARS_STEP, 4);  // -100 is a common year
    send_cmd(-32768, 12, 31, OP_YEARS_STEP, 1);
    send_cmd(-32768, 6, 10, OP_YEARS_DIR,  65535);
    send_cmd(32767,  2, 29, OP_YEARS_DIR,  0);
    send_cmd(0,      2, 29, OP_MONTHS,     0);
  endtask

  // Bulk random traffic with gaps on both sides; midway the sender drains.
  task automatic test_random_traffic();
    for (int i = 0; i < 80; i++) begin
      if (i == 40) wait_for_results();
      send_random_cmd();
    end
  endtask

  // Back-to-back commands with the result side always ready.
  task automatic test_back_to_back();
    steady_flow = 1'b1;
    for (int i = 0; i < 16; i++) send_random_cmd();
    wait_for_results();
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    steady_flow = 1'b0;
    ready_hold  = 0;
    ready_level = 1'b1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_input_clamping();
    test_day_steps();
    test_month_steps();
    test_year_steps();
    test_random_traffic();
    test_back_to_back();

    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d day, %0d month, %0d stepwise-year and %0d direct-year commands,",
             cmds_by_op[OP_DAYS], cmds_by_op[OP_MONTHS],
             cmds_by_op[OP_YEARS_STEP], cmds_by_op[OP_YEARS_DIR]);
    $display("clamped inputs, leap and wrap corners included; %0d results checked.",
             results_checked);
    if (mismatches == 0)
      $display("** calendar_date_decrement_top: PASSED **");
    else
      $display("** calendar_date_decrement_top: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/cdd_pkg.sv
hw/rtl/calendar_date_decrement_top.sv
hw/rtl/cdd_checker.sv
sim/tb_calendar_date_decrement_top.sv
